// ===== sv/grc_pkg.sv =====
// Package for the guarded record checker: constants, codes and CRC helper.
package grc_pkg;

    localparam int COUNT_BITS_DEF     = 32;
    localparam int IDENTITY_BYTES_DEF = 32;

    localparam int MAGIC_LEN    = 8;
    localparam int LEN_FIELD    = 8;
    localparam int TRAILER_LEN  = 4;
    localparam int ID_REG_BYTES = 32;
    localparam int CFG_BITS     = 64;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_RAW_OK       = 3'd0,
        ST_GUARDED_OK   = 3'd1,
        ST_ID_NEEDED    = 3'd2,
        ST_BAD_ID       = 3'd3,
        ST_SHORT        = 3'd4,
        ST_LENGTH       = 3'd5,
        ST_ID_MISMATCH  = 3'd6,
        ST_CRC          = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ID_GIVEN  = 3'd0,
        REG_ID_LENGTH = 3'd1,
        REG_ID_WORD0  = 3'd2,
        REG_ID_WORD1  = 3'd3,
        REG_ID_WORD2  = 3'd4,
        REG_ID_WORD3  = 3'd5
    } cfg_reg_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] m;
        case (idx)
            3'd0:    m = 8'h52;
            3'd1:    m = 8'h53;
            3'd2:    m = 8'h47;
            3'd3:    m = 8'h55;
            3'd4:    m = 8'h41;
            3'd5:    m = 8'h52;
            3'd6:    m = 8'h44;
            default: m = 8'h01;
        endcase
        return m;
    endfunction

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] id_byte(input logic [8*ID_REG_BYTES-1:0] v,
                                          input logic [4:0] i);
        return v[{i, 3'b000} +: 8];
    endfunction

endpackage

// ===== sv/guarded_record_checker_unit.sv =====
// Guarded record checker: streaming snapshot check with CRC-32 trailer.
//
//  channel   | signals                       | contents
//  ----------+-------------------------------+------------------------------------------
//  s_axis    | s_tvalid s_tready s_tdata     | tdata[7:0] data_byte; tlast final_byte
//            | s_tlast                       |
//  m_axis    | m_tvalid m_tready m_tdata     | [2:0] status, [8:3] payload_offset,
//            |                               | [40:9] payload_length, rest zero
//  cfg       | cfg_we cfg_index cfg_data     | index 0..5 per register list
//
// One word per cycle unless a final word stalls: a word is held in the input
// register, then the CRC byte update, header compares and verdict settle into
// the state and result registers.
// Reset clears stream state, configuration and valid flags; data registers are
// not reset. A full result register stalls only a final word; other words keep flowing.
module guarded_record_checker_unit #(
    parameter int COUNT_BITS     = grc_pkg::COUNT_BITS_DEF,
    parameter int IDENTITY_BYTES = grc_pkg::IDENTITY_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // final_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // status, payload_offset, payload_length
    input  logic                              cfg_we,
    input  logic [grc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [grc_pkg::CFG_BITS-1:0]      cfg_data
);
    import grc_pkg::*;

    localparam int PREFIX_LEN   = MAGIC_LEN + LEN_FIELD + IDENTITY_BYTES;
    localparam int OVERHEAD_LEN = PREFIX_LEN + TRAILER_LEN;
    localparam logic [COUNT_BITS-1:0] C_MAGIC    = COUNT_BITS'(MAGIC_LEN);
    localparam logic [COUNT_BITS-1:0] C_LENEND   = COUNT_BITS'(MAGIC_LEN + LEN_FIELD);
    localparam logic [COUNT_BITS-1:0] C_PREFIX   = COUNT_BITS'(PREFIX_LEN);
    localparam logic [COUNT_BITS-1:0] C_OVERHEAD = COUNT_BITS'(OVERHEAD_LEN);
    localparam logic [COUNT_BITS-1:0] C_TRAILER  = COUNT_BITS'(TRAILER_LEN);
    localparam logic [6:0]            ID_BYTES7  = 7'(IDENTITY_BYTES);
    localparam logic [5:0]            OFFSET_OK  = 6'(PREFIX_LEN);

    // configuration
    logic                       id_given_reg;
    logic [4:0]                 id_length_reg;
    logic [CFG_BITS-1:0]        id_word_reg [4];
    logic [4:0]                 eff_len;
    logic [8*ID_REG_BYTES-1:0]  id_vec;

    // input stage
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;

    // stream state
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic                       magic_reg, magic_next;
    logic [63:0]                hlen_reg, hlen_next;
    logic                       idm_reg, idm_next;
    logic [31:0]                crc_reg, crc_next;
    logic [31:0]                tail_reg, tail_next;

    // result stage
    logic                       out_valid_reg;
    status_t                    out_status_reg, status_next;
    logic [5:0]                 out_offset_reg, offset_next;
    logic [31:0]                out_length_reg, length_next;

    logic                       advance;
    logic [6:0]                 id_off;
    logic [7:0]                 id_expect;
    logic [31:0]                trailer;
    logic [COUNT_BITS-1:0]      body_len;

    assign id_vec = {id_word_reg[3], id_word_reg[2], id_word_reg[1], id_word_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_given_reg   <= 1'b0;
            id_length_reg  <= '0;
            id_word_reg[0] <= '0;
            id_word_reg[1] <= '0;
            id_word_reg[2] <= '0;
            id_word_reg[3] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ID_GIVEN:  id_given_reg   <= cfg_data[0];
                    REG_ID_LENGTH: id_length_reg  <= cfg_data[4:0];
                    REG_ID_WORD0:  id_word_reg[0] <= cfg_data;
                    REG_ID_WORD1:  id_word_reg[1] <= cfg_data;
                    REG_ID_WORD2:  id_word_reg[2] <= cfg_data;
                    REG_ID_WORD3:  id_word_reg[3] <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // identity ends at its length or its first zero byte
    always_comb
    begin
        eff_len = id_length_reg;
        for (int j = ID_REG_BYTES - 2; j >= 0; j--)
        begin
            if (id_byte(id_vec, 5'(j)) == 8'd0 && 5'(j) < id_length_reg)
            begin
                eff_len = 5'(j);
            end
        end
    end

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        magic_next = magic_reg;
        hlen_next  = hlen_reg;
        idm_next   = idm_reg;
        id_off     = 7'(count_reg - C_LENEND);
        id_expect  = (id_off < {2'b00, eff_len}) ? id_byte(id_vec, id_off[4:0]) : 8'd0;

        if (count_reg < C_MAGIC)
        begin
            if (in_byte_reg != magic_byte(count_reg[2:0]))
            begin
                magic_next = 1'b0;
            end
        end
        else if (count_reg < C_LENEND)
        begin
            hlen_next = hlen_reg | (64'(in_byte_reg) << {count_reg[2:0], 3'b000});
        end
        else if (count_reg < C_PREFIX)
        begin
            if (in_byte_reg != id_expect)
            begin
                idm_next = 1'b0;
            end
        end

        crc_next   = (count_reg >= C_TRAILER) ? crc_feed(crc_reg, tail_reg[31:24]) : crc_reg;
        tail_next  = {tail_reg[23:0], in_byte_reg};
        count_next = (&count_reg) ? count_reg : count_reg + 1'b1;

        trailer  = {tail_next[7:0], tail_next[15:8], tail_next[23:16], tail_next[31:24]};
        body_len = count_next - C_OVERHEAD;

        offset_next = '0;
        length_next = '0;
        if (!(count_next >= C_MAGIC && magic_next))
        begin
            if (id_given_reg)
            begin
                status_next = ST_ID_MISMATCH;
            end
            else
            begin
                status_next = ST_RAW_OK;
                length_next = 32'(count_next);
            end
        end
        else if (!id_given_reg)
        begin
            status_next = ST_ID_NEEDED;
        end
        else if (eff_len == 5'd0 || {2'b00, eff_len} >= ID_BYTES7)
        begin
            status_next = ST_BAD_ID;
        end
        else if (count_next < C_OVERHEAD)
        begin
            status_next = ST_SHORT;
        end
        else if (hlen_next != 64'(body_len))
        begin
            status_next = ST_LENGTH;
        end
        else if (!idm_next)
        begin
            status_next = ST_ID_MISMATCH;
        end
        else if (trailer != ~crc_next)
        begin
            status_next = ST_CRC;
        end
        else
        begin
            status_next = ST_GUARDED_OK;
            offset_next = OFFSET_OK;
            length_next = hlen_next[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            magic_reg     <= 1'b1;
            hlen_reg      <= '0;
            idm_reg       <= 1'b1;
            crc_reg       <= CRC_INIT;
            tail_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (advance)
            begin
                if (in_last_reg)
                begin
                    count_reg <= '0;
                    magic_reg <= 1'b1;
                    hlen_reg  <= '0;
                    idm_reg   <= 1'b1;
                    crc_reg   <= CRC_INIT;
                    tail_reg  <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    magic_reg <= magic_next;
                    hlen_reg  <= hlen_next;
                    idm_reg   <= idm_next;
                    crc_reg   <= crc_next;
                    tail_reg  <= tail_next;
                end
            end

            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_status_reg <= status_next;
            out_offset_reg <= offset_next;
            out_length_reg <= length_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_length_reg, out_offset_reg, out_status_reg};

endmodule

// ===== dv/tb_guarded_record_checker_unit.sv =====
// Testbench for guarded_record_checker_unit: directed and random framed snapshots checked against a predictor.
`timescale 1ns / 1ps

module tb_guarded_record_checker_unit;
    import grc_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_LENGTH,
        FLAW_ID,
        FLAW_CRC,
        FLAW_SHORT
    } flaw_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } word_t;

    typedef struct {
        status_t     st;
        logic [5:0]  off;
        logic [31:0] plen;
    } verdict_t;

    localparam logic [63:0] MAGIC_WORD = 64'h01_44_52_41_55_47_53_52;
    localparam int          PREFIX     = MAGIC_LEN + LEN_FIELD + IDENTITY_BYTES_DEF;
    localparam int          OVERHEAD   = PREFIX + TRAILER_LEN;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_ID_GIVEN;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    // register copies
    logic         id_given_q = 1'b0;
    logic [4:0]   id_len_q = 5'd0;
    logic [255:0] id_bits_q = '0;

    // stream state of the predictor
    logic [31:0]  rec_count;
    logic         magic_ok;
    logic [63:0]  len_field;
    logic         ident_ok;
    logic [31:0]  crc_acc;
    logic [31:0]  last4;

    word_t        word_q[$];
    verdict_t     verdict_q[$];
    logic [7:0]   frame_buf[$];
    word_t        cur_word;
    verdict_t     got_v;

    bit           word_taken = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_req = 0;
    int           hold_ack = 0;
    int           hold_left = 0;
    int           err_count = 0;

    guarded_record_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] id_raw(int i);
        return (i < ID_REG_BYTES) ? id_bits_q[8*i +: 8] : 8'd0;
    endfunction

    // identity ends at the length or at its first zero byte
    function automatic int id_eff_len();
        int n;
        n = 0;
        while (n < id_len_q && id_raw(n) != 8'd0)
            n++;
        return n;
    endfunction

    function automatic logic [7:0] id_pad_byte(int i);
        return (i < id_eff_len()) ? id_raw(i) : 8'd0;
    endfunction

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        int          k;
        r = c;
        for (k = 0; k < 8; k++)
            r = (r[0] ^ b[k]) ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
        return r;
    endfunction

    function automatic void clear_record();
        rec_count = '0;
        magic_ok  = 1'b1;
        len_field = '0;
        ident_ok  = 1'b1;
        crc_acc   = 32'hFFFF_FFFF;
        last4     = '0;
    endfunction

    function automatic void absorb_word(logic [7:0] b, logic fin);
        verdict_t    v;
        logic [31:0] idx;
        logic [31:0] trailer;
        int          n;
        idx = rec_count;
        if (idx < MAGIC_LEN)
        begin
            if (b != MAGIC_WORD[8*idx +: 8])
                magic_ok = 1'b0;
        end
        else if (idx < MAGIC_LEN + LEN_FIELD)
            len_field |= 64'(b) << (8 * (idx - MAGIC_LEN));
        else if (idx < PREFIX)
        begin
            if (b != id_pad_byte(idx - MAGIC_LEN - LEN_FIELD))
                ident_ok = 1'b0;
        end
        // trailer bytes are held back four words before entering the CRC
        if (idx >= TRAILER_LEN)
            crc_acc = crc_step(crc_acc, last4[31:24]);
        last4 = {last4[23:0], b};
        if (rec_count != 32'hFFFF_FFFF)
            rec_count++;
        if (!fin)
            return;
        v.off  = 6'd0;
        v.plen = 32'd0;
        if (!(rec_count >= MAGIC_LEN && magic_ok))
        begin
            if (id_given_q)
                v.st = ST_ID_MISMATCH;
            else
            begin
                v.st   = ST_RAW_OK;
                v.plen = rec_count;
            end
        end
        else
        begin
            n = id_eff_len();
            trailer = {last4[7:0], last4[15:8], last4[23:16], last4[31:24]};
            if (!id_given_q)
                v.st = ST_ID_NEEDED;
            else if (n == 0 || n >= IDENTITY_BYTES_DEF)
                v.st = ST_BAD_ID;
            else if (rec_count < OVERHEAD)
                v.st = ST_SHORT;
            else if (len_field != {32'd0, rec_count} - OVERHEAD)
                v.st = ST_LENGTH;
            else if (!ident_ok)
                v.st = ST_ID_MISMATCH;
            else if (trailer != ~crc_acc)
                v.st = ST_CRC;
            else
            begin
                v.st   = ST_GUARDED_OK;
                v.off  = 6'(PREFIX);
                v.plen = len_field[31:0];
            end
        end
        verdict_q.push_back(v);
        clear_record();
    endfunction

    // accept, predict and check on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result with none expected: %h", m_tdata);
                    err_count++;
                end
                else
                begin
                    got_v = verdict_q.pop_front();
                    if (m_tdata[2:0] !== got_v.st)
                    begin
                        $error("status: expected %0d, got %0d", got_v.st, m_tdata[2:0]);
                        err_count++;
                    end
                    if (m_tdata[8:3] !== got_v.off)
                    begin
                        $error("payload_offset: expected %0d, got %0d", got_v.off, m_tdata[8:3]);
                        err_count++;
                    end
                    if (m_tdata[40:9] !== got_v.plen)
                    begin
                        $error("payload_length: expected %0d, got %0d",
                               got_v.plen, m_tdata[40:9]);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                word_taken = 1'b1;
                absorb_word(s_tdata, s_tlast);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!s_tvalid || word_taken)
        begin
            word_taken = 1'b0;
            if (rst_n && word_q.size() != 0
                && !(word_q[0].hold && verdict_q.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cur_word = word_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= cur_word.data;
                s_tlast  <= cur_word.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = 400;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic write_reg(cfg_reg_t r, logic [63:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (r)
            REG_ID_GIVEN:  id_given_q = v[0];
            REG_ID_LENGTH: id_len_q = v[4:0];
            REG_ID_WORD0:  id_bits_q[63:0] = v;
            REG_ID_WORD1:  id_bits_q[127:64] = v;
            REG_ID_WORD2:  id_bits_q[191:128] = v;
            default:       id_bits_q[255:192] = v;
        endcase
    endtask

    task automatic set_identity(logic given, logic [4:0] len, logic [255:0] bits);
        write_reg(REG_ID_GIVEN, {63'd0, given});
        write_reg(REG_ID_LENGTH, {59'd0, len});
        write_reg(REG_ID_WORD0, bits[63:0]);
        write_reg(REG_ID_WORD1, bits[127:64]);
        write_reg(REG_ID_WORD2, bits[191:128]);
        write_reg(REG_ID_WORD3, bits[255:192]);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 53; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    task automatic settle();
        while (word_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic emit_frame(bit hold_first);
        word_t w;
        int    i;
        for (i = 0; i < frame_buf.size(); i++)
        begin
            w.data = frame_buf[i];
            w.last = (i == frame_buf.size() - 1);
            w.hold = hold_first && (i == 0);
            word_q.push_back(w);
        end
    endtask

    task automatic build_raw(int n, bit magic_lead);
        int i;
        frame_buf.delete();
        for (i = 0; i < n; i++)
            frame_buf.push_back((magic_lead && i < MAGIC_LEN) ? MAGIC_WORD[8*i +: 8]
                                                             : 8'($urandom_range(0, 255)));
    endtask

    task automatic build_guarded(int plen, flaw_t flaw);
        logic [63:0] lf;
        logic [31:0] c;
        int          i;
        int          keep;
        frame_buf.delete();
        lf = 64'(plen);
        if (flaw == FLAW_LENGTH)
            lf ^= 64'd1 << $urandom_range(0, 63);
        for (i = 0; i < MAGIC_LEN; i++)
            frame_buf.push_back(MAGIC_WORD[8*i +: 8]);
        for (i = 0; i < LEN_FIELD; i++)
            frame_buf.push_back(lf[8*i +: 8]);
        for (i = 0; i < IDENTITY_BYTES_DEF; i++)
            frame_buf.push_back(id_pad_byte(i));
        for (i = 0; i < plen; i++)
            frame_buf.push_back(8'($urandom_range(0, 255)));
        if (flaw == FLAW_MAGIC)
            frame_buf[$urandom_range(0, MAGIC_LEN - 1)] ^= 8'($urandom_range(1, 255));
        if (flaw == FLAW_ID)
            frame_buf[MAGIC_LEN + LEN_FIELD + $urandom_range(0, IDENTITY_BYTES_DEF - 1)]
                ^= 8'($urandom_range(1, 255));
        c = 32'hFFFF_FFFF;
        for (i = 0; i < frame_buf.size(); i++)
            c = crc_step(c, frame_buf[i]);
        c = ~c;
        if (flaw == FLAW_CRC)
            c ^= 32'd1 << $urandom_range(0, 31);
        for (i = 0; i < TRAILER_LEN; i++)
            frame_buf.push_back(c[8*i +: 8]);
        if (flaw == FLAW_SHORT)
        begin
            keep = $urandom_range(MAGIC_LEN, OVERHEAD - 1);
            while (frame_buf.size() > keep)
                void'(frame_buf.pop_back());
        end
    endtask

    function automatic logic [63:0] rand_id_word(bit dense);
        logic [63:0] w;
        int          i;
        for (i = 0; i < 8; i++)
            w[8*i +: 8] = (dense || $urandom_range(0, 15) != 0) ? 8'($urandom_range(1, 255))
                                                               : 8'd0;
        return w;
    endfunction

    task automatic random_frame(bit hold_first);
        int plen;
        if ($urandom_range(0, 9) < 7)
        begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
            if ($urandom_range(0, 1) == 0)
                build_guarded(plen, FLAW_NONE);
            else
                build_guarded(plen, flaw_t'($urandom_range(FLAW_MAGIC, FLAW_SHORT)));
        end
        else
            build_raw($urandom_range(1, 24), $urandom_range(0, 3) == 0);
        emit_frame(hold_first);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_guarded_record_checker_unit: errors");
        $finish;
    end

    initial
    begin
        int           ph;
        int           i;
        logic [255:0] bits;
        clear_record();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // no identity: raw passes, guarded asks for one
        set_idling(0);
        build_raw(1, 1'b0);
        frame_buf[0] = 8'h00;
        emit_frame(1'b0);
        build_raw(1, 1'b0);
        frame_buf[0] = 8'hFF;
        emit_frame(1'b0);
        build_raw(7, 1'b1);
        emit_frame(1'b0);
        build_guarded(0, FLAW_NONE);
        emit_frame(1'b0);
        settle();

        set_identity(1'b1, 5'd5, {192'd0, 64'h6463_6261_3433_3231});
        build_raw(3, 1'b0);
        emit_frame(1'b0);
        build_guarded(0, FLAW_NONE);
        emit_frame(1'b0);
        for (i = FLAW_MAGIC; i <= FLAW_SHORT; i++)
        begin
            build_guarded(0, flaw_t'(i));
            emit_frame(1'b0);
        end
        settle();

        // empty identity, identity cut by a zero byte, longest identity
        set_identity(1'b1, 5'd0, {4{64'h4142_4344_4546_4748}});
        build_guarded(0, FLAW_NONE);
        emit_frame(1'b0);
        settle();
        set_identity(1'b1, 5'd31, '0);
        build_guarded(0, FLAW_NONE);
        emit_frame(1'b0);
        settle();
        set_identity(1'b1, 5'd31, {256{1'b1}});
        build_guarded(4, FLAW_NONE);
        emit_frame(1'b0);
        settle();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_identity(1'b1, 5'd31, {256{1'b1}});
                3:       set_identity(1'b0, 5'd0, '0);
                default:
                begin
                    bits = {rand_id_word(1'b0), rand_id_word(1'b0),
                            rand_id_word(1'b0), rand_id_word(1'b1)};
                    set_identity($urandom_range(0, 5) != 0, 5'($urandom_range(0, 31)), bits);
                end
            endcase
            set_idling(ph);
            random_frame(1'b0);
            if (ph == 1)
            begin
                // back-pressure: short raw frames pile up while the result side holds off
                for (i = 0; i < 10; i++)
                begin
                    build_raw($urandom_range(1, 2), 1'b0);
                    emit_frame(1'b0);
                end
                hold_req++;
            end
            if (ph == 2)
            begin
                // sender waits until every pending result is out
                build_raw(2, 1'b0);
                emit_frame(1'b1);
            end
            settle();
        end

        repeat (10) @(negedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d results never arrived", verdict_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("tb_guarded_record_checker_unit: clean");
        else
            $display("tb_guarded_record_checker_unit: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/grc_pkg.sv
sv/guarded_record_checker_unit.sv
dv/tb_guarded_record_checker_unit.sv
